/* rtl/b58enc_pkg.sv */
// ============================================================================
// b58enc_pkg : shared types and constants for the base58 encoder
// Holds the sequencer states, the radix and the character table lookup.
// ============================================================================
`default_nettype none

package b58enc_pkg;

    // base of the output digits
    localparam logic [6:0] RADIX    = 7'd58;
    // ascii code of the zero digit '1'
    localparam logic [6:0] ONE_CHAR = 7'd49;

    // sequencer states
    typedef enum logic [2:0] {
        S_COLLECT,
        S_DIV_RD,
        S_DIV_END,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // digit value to ascii, alphabet 1-9 A-Z a-z without 0 O I l
    function automatic logic [6:0] b58_char(input logic [5:0] d);
        logic [6:0] code;
        case (d) inside
            [6'd0:6'd8]:   code = 7'(d) + 7'd49;
            [6'd9:6'd16]:  code = 7'(d) + 7'd56;
            [6'd17:6'd21]: code = 7'(d) + 7'd57;
            [6'd22:6'd32]: code = 7'(d) + 7'd58;
            [6'd33:6'd43]: code = 7'(d) + 7'd64;
            [6'd44:6'd57]: code = 7'(d) + 7'd65;
            default:       code = ONE_CHAR;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/b58enc_divider.sv */
// ============================================================================
// b58enc_divider : one long-division step by 58
// Divides (remainder * 256 + byte) by 58 through a scaled reciprocal
// multiplication, giving an 8-bit quotient byte and the new 6-bit remainder.
// ============================================================================
`default_nettype none

module b58enc_divider
    import b58enc_pkg::*;
(
    input  wire logic [5:0] i_rem,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_quot,
    output logic      [5:0] o_rem
);

    // ceil(2^20 / 58), exact for every dividend below 58 * 256
    localparam logic [14:0] RECIP = 15'd18079;

    logic [13:0] dividend;
    logic [27:0] product;
    logic [13:0] back;

    // quotient from the reciprocal, remainder by multiply and subtract
    assign dividend = {i_rem, i_byte};
    assign product  = 28'(dividend) * 28'(RECIP);
    assign o_quot   = product[27:20];
    assign back     = 14'(o_quot) * 14'(RADIX);
    assign o_rem    = 6'(dividend - back);

endmodule

`default_nettype wire

/* rtl/base58_encoder_25_byte_core.sv */
// ============================================================================
// base58_encoder_25_byte_core : fixed-length base58 encoder
// Collects a big-endian payload and emits its base58 text, most significant
// character first, with a mark on the last character.
// ============================================================================
// The block takes PAYLOAD_BYTES payload bytes, one per cycle, into a byte
// memory, counting leading zero bytes on the way. After the final byte it
// stalls its input and runs DIGITS long-division passes by 58 over that
// memory, each a read-modify-write sweep of all PAYLOAD_BYTES bytes through
// its separate read and write ports, storing one digit per pass in a digit
// memory. It then emits one '1' per leading zero byte followed by the
// significant digits, each character going through a read state and a load
// state, S_EMIT_RD and S_EMIT_LD, and waiting while the output is stalled.
// A value of 58^DIGITS or more keeps only its low DIGITS digits; an encoding
// that would be empty is sent as a single '1'.
`default_nettype none

module base58_encoder_25_byte_core
    import b58enc_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 25,
    parameter int DIGITS        = 34
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // payload byte channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_payload_byte,
    // character channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [6:0] o_char_code,
    output logic            o_last_char
);

    localparam int PW  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int PCW = $clog2(PAYLOAD_BYTES + 1);
    localparam int DW  = $clog2(DIGITS);
    localparam int DCW = $clog2(DIGITS + 1);
    localparam int CW  = (PCW > DCW) ? PCW : DCW;

    t_state r_state, n_state;

    logic [PW-1:0]  r_count;
    logic [PCW-1:0] r_zeros;
    logic           r_all_zero;
    logic [PW-1:0]  r_rd_idx;
    logic [PW-1:0]  r_proc_idx;
    logic           r_proc_pend;
    logic [5:0]     r_rem;
    logic [DW-1:0]  r_pass;
    logic [DCW-1:0] r_first;
    logic [DCW-1:0] r_ones_left;
    logic [DCW-1:0] r_dig_addr;
    logic [7:0]     r_pay_rd;
    logic [5:0]     r_dig_rd;
    logic           r_o_valid;
    logic [6:0]     r_o_char;
    logic           r_o_last;

    logic [7:0] r_pay_mem [PAYLOAD_BYTES];
    logic [5:0] r_dig_mem [DIGITS];

    logic           in_acc;
    logic           out_acc;
    logic           last_byte;
    logic           pass_last_rd;
    logic [7:0]     div_quot;
    logic [5:0]     div_rem;
    logic [DCW-1:0] first_fin;
    logic [DCW-1:0] ones_calc;
    logic           emit_ones;
    logic           emit_last;
    logic           emit_go;
    logic           pay_we;
    logic [PW-1:0]  pay_waddr;
    logic [7:0]     pay_wdata;
    logic           dig_we;
    logic           dig_re;

    // handshakes
    assign in_acc  = i_valid && (r_state == S_COLLECT);
    assign out_acc = r_o_valid && !i_stall;

    // one division step on the byte just read
    b58enc_divider u_div (
        .i_rem  (r_rem),
        .i_byte (r_pay_rd),
        .o_quot (div_quot),
        .o_rem  (div_rem)
    );

    // sweep and character bookkeeping
    assign last_byte    = (r_count == PW'(PAYLOAD_BYTES - 1));
    assign pass_last_rd = (r_rd_idx == PW'(PAYLOAD_BYTES - 1));
    assign first_fin    = (div_rem != 6'd0) ? DCW'(r_pass) : r_first;

    // leading '1' count, capped by the digit room, never an empty string
    always_comb begin
        if (CW'(r_zeros) < CW'(first_fin)) begin
            ones_calc = DCW'(r_zeros);
        end else begin
            ones_calc = first_fin;
        end
        if (first_fin == DCW'(DIGITS) && r_zeros == '0) begin
            ones_calc = DCW'(1);
        end
    end

    assign emit_ones = (r_ones_left != '0);
    assign emit_last = (r_ones_left == DCW'(1) && r_first == DCW'(DIGITS))
                    || (!emit_ones && r_dig_addr == DCW'(DIGITS - 1));
    assign emit_go   = !r_o_valid || out_acc;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (in_acc && last_byte) n_state = S_DIV_RD;
            end
            S_DIV_RD: begin
                if (pass_last_rd) n_state = S_DIV_END;
            end
            S_DIV_END: begin
                n_state = (r_pass == '0) ? S_EMIT_RD : S_DIV_RD;
            end
            S_EMIT_RD: begin
                if (emit_go) n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_state = emit_last ? S_COLLECT : S_EMIT_RD;
            end
            default: n_state = S_COLLECT;
        endcase
    end

    // memory strobes and input stall
    always_comb begin
        o_stall   = 1'b1;
        pay_we    = 1'b0;
        pay_waddr = r_proc_idx;
        pay_wdata = div_quot;
        dig_we    = 1'b0;
        dig_re    = 1'b0;
        unique case (r_state)
            S_COLLECT: begin
                o_stall   = 1'b0;
                pay_we    = in_acc;
                pay_waddr = r_count;
                pay_wdata = i_payload_byte;
            end
            S_DIV_RD: begin
                pay_we = r_proc_pend;
            end
            S_DIV_END: begin
                pay_we = 1'b1;
                dig_we = 1'b1;
            end
            S_EMIT_RD: begin
                dig_re = emit_go && !emit_ones;
            end
            S_EMIT_LD: begin
                o_stall = 1'b1;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // payload / work memory
    always_ff @(posedge i_clk) begin
        if (pay_we) r_pay_mem[pay_waddr] <= pay_wdata;
        r_pay_rd <= r_pay_mem[r_rd_idx];
    end

    // digit memory
    always_ff @(posedge i_clk) begin
        if (dig_we) r_dig_mem[r_pass] <= div_rem;
        if (dig_re) r_dig_rd <= r_dig_mem[r_dig_addr[DW-1:0]];
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_proc_pend <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register
            if (r_state == S_EMIT_LD) begin
                r_o_valid <= 1'b1;
                r_o_char  <= emit_ones ? ONE_CHAR : b58_char(r_dig_rd);
                r_o_last  <= emit_last;
                if (emit_ones) r_ones_left <= r_ones_left - 1'b1;
                else           r_dig_addr  <= r_dig_addr + 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_COLLECT: begin
                    if (in_acc) begin
                        r_count <= last_byte ? '0 : r_count + 1'b1;
                        // leading zero byte count
                        if (r_count == '0) begin
                            r_zeros    <= (i_payload_byte == 8'd0) ? PCW'(1) : '0;
                            r_all_zero <= (i_payload_byte == 8'd0);
                        end else if (r_all_zero && i_payload_byte == 8'd0) begin
                            r_zeros <= r_zeros + 1'b1;
                        end else begin
                            r_all_zero <= 1'b0;
                        end
                        if (last_byte) begin
                            r_rd_idx    <= '0;
                            r_proc_pend <= 1'b0;
                            r_rem       <= '0;
                            r_pass      <= DW'(DIGITS - 1);
                            r_first     <= DCW'(DIGITS);
                        end
                    end
                end
                S_DIV_RD: begin
                    r_rd_idx    <= pass_last_rd ? '0 : r_rd_idx + 1'b1;
                    r_proc_idx  <= r_rd_idx;
                    r_proc_pend <= !pass_last_rd;
                    if (r_proc_pend) r_rem <= div_rem;
                end
                S_DIV_END: begin
                    r_rem       <= '0;
                    r_first     <= first_fin;
                    r_proc_pend <= 1'b0;
                    r_pass      <= r_pass - 1'b1;
                    if (r_pass == '0) begin
                        r_ones_left <= ones_calc;
                        r_dig_addr  <= first_fin;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_o_char;
    assign o_last_char = r_o_last;

endmodule

`default_nettype wire

/* rtl/b58enc_checker.sv */
// ============================================================================
// b58enc_checker : port-level checks for the base58 encoder
// Watches the character channel and the input stall of the top level.
// ============================================================================
`default_nettype none

module b58enc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [6:0] o_char_code,
    input wire logic       o_last_char
);

    // no character straight after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("character valid after reset");

    // a stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code)
                               && $stable(o_last_char))
        else $error("stalled character changed");

    // only the final character may wait while bytes are taken
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_stall |-> o_last_char)
        else $error("input open while encoding incomplete");

    // a new encoding cannot follow the last character at once
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_char |=> !o_valid)
        else $error("character straight after last transaction");

    // characters stay within the alphabet range
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_char_code >= 7'd49 && o_char_code <= 7'd122)
        else $error("character code out of range");

endmodule

bind base58_encoder_25_byte_core b58enc_checker u_b58enc_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// ============================================================================
// testbench : self-checking bench for base58_encoder_25_byte_core
// Feeds 25-byte payloads a byte per transaction and predicts the Base58 text
// by long division by 58. Each character transaction is checked in order,
// code and last-character mark separately, under random idling on both sides.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b58enc_pkg::*;

    localparam int PAYLOAD_BYTES = 25;
    localparam int DIGITS        = 34;
    localparam int PAYLOAD_BITS  = 8 * PAYLOAD_BYTES;
    localparam int LONG_HOLD     = 2000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;

    // one character of the expected text
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    // prediction of the encoded text and in-order comparison
    class t_encoding_scoreboard;
        logic [7:0]  payload_bytes[PAYLOAD_BYTES];
        int unsigned byte_idx;
        t_text_char  expected_text[$];
        int unsigned errors;
        int unsigned payloads_done;
        int unsigned chars_checked;
        string       alphabet58 =
            "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

        function int pending();
            return expected_text.size();
        endfunction

        // store an accepted byte, predict the text once the payload is whole
        function void note_byte(logic [7:0] b);
            payload_bytes[byte_idx] = b;
            byte_idx++;
            if (byte_idx == PAYLOAD_BYTES) begin
                byte_idx = 0;
                payloads_done++;
                predict_text();
            end
        endfunction

        function void predict_text();
            logic [7:0]  work[PAYLOAD_BYTES];
            logic [5:0]  digits[DIGITS];
            int unsigned rem;
            int          zeros;
            int          first;
            int          nd;
            int          ones;
            int          total;
            int          k;
            t_text_char  c;
            work = payload_bytes;
            // repeated long division, low digit first; keeps value mod 58^DIGITS
            for (int n = DIGITS - 1; n >= 0; n--) begin
                rem = 0;
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    rem = rem * 256 + work[i];
                    work[i] = 8'(rem / RADIX);
                    rem = rem % RADIX;
                end
                digits[n] = 6'(rem);
            end
            zeros = 0;
            while (zeros < PAYLOAD_BYTES && payload_bytes[zeros] == 8'h00)
                zeros++;
            first = 0;
            while (first < DIGITS && digits[first] == 6'd0)
                first++;
            nd = DIGITS - first;
            ones = zeros;
            // the text never grows past DIGITS characters
            if (ones > DIGITS - nd)
                ones = DIGITS - nd;
            total = ones + nd;
            // nothing left to print: a lone '1'
            if (total == 0) begin
                c.code = ONE_CHAR;
                c.last = 1'b1;
                expected_text.push_back(c);
                return;
            end
            k = 0;
            for (int i = 0; i < ones; i++) begin
                c.code = ONE_CHAR;
                c.last = (k == total - 1);
                expected_text.push_back(c);
                k++;
            end
            for (int i = first; i < DIGITS; i++) begin
                c.code = 7'(alphabet58[digits[i]]);
                c.last = (k == total - 1);
                expected_text.push_back(c);
                k++;
            end
        endfunction

        // compare one accepted character with the oldest expectation
        function void check_char(logic [6:0] code, logic last);
            t_text_char exp_c;
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected character, expected none actual code %0d last %0b",
                         $time, code, last);
                errors++;
                return;
            end
            exp_c = expected_text.pop_front();
            chars_checked++;
            if (code !== exp_c.code) begin
                $display("%0t: char_code mismatch, expected %0d actual %0d",
                         $time, exp_c.code, code);
                errors++;
            end
            if (last !== exp_c.last) begin
                $display("%0t: last_char mismatch, expected %0b actual %0b",
                         $time, exp_c.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_payload_byte;
    logic       o_valid;
    logic       i_stall;
    logic [6:0] o_char_code;
    logic       o_last_char;

    t_encoding_scoreboard sb = new();

    bit tx_fast;
    bit rx_fast;
    bit long_hold_req;
    int unsigned cycle_count;
    logic [PAYLOAD_BITS-1:0] modulus58;

    base58_encoder_25_byte_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .DIGITS        (DIGITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_payload_byte (i_payload_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_char_code    (o_char_code),
        .o_last_char    (o_last_char)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d characters outstanding",
                         cycle_count, sb.pending());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // character monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_char(o_char_code, o_last_char);
    end

    // character receiver: random stall per transaction, one long hold on request
    initial begin : receiver
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                hold = rx_fast ? 0 : $urandom_range(0, 4);
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    // count stall cycles only while a character is on offer
                    while (hold > 0) begin
                        @(negedge i_clk);
                        if (o_valid === 1'b1)
                            hold--;
                    end
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_rst_n === 1'b1));
        end
    end

    // one byte transaction; called and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_payload_byte <= b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    // payload value sent most significant byte first
    task automatic send_payload(input logic [PAYLOAD_BITS-1:0] value);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            send_byte(value[8 * (PAYLOAD_BYTES - 1 - i) +: 8]);
    endtask

    function automatic logic [PAYLOAD_BITS-1:0] random_value();
        logic [PAYLOAD_BITS-1:0] v;
        v = '0;
        repeat ((PAYLOAD_BITS + 31) / 32)
            v = (v << 32) | PAYLOAD_BITS'($urandom);
        return v;
    endfunction

    // random payload of a drawn shape
    function automatic logic [PAYLOAD_BITS-1:0] shaped_value();
        logic [PAYLOAD_BITS-1:0] v;
        v = random_value();
        case ($urandom_range(0, 4))
            // leading zero bytes
            1: v = v >> (8 * $urandom_range(1, PAYLOAD_BYTES - 1));
            // just around 58^DIGITS, where the value wraps
            2: begin
                v = v >> (8 * $urandom_range(1, PAYLOAD_BYTES - 1));
                v = $urandom_range(0, 1) ? modulus58 + v : modulus58 - v;
            end
            // run of 0xff bytes at the top
            3: v = v | ({PAYLOAD_BITS{1'b1}} << (8 * $urandom_range(1, PAYLOAD_BYTES - 1)));
            // zero byte somewhere inside
            4: v[8 * $urandom_range(0, PAYLOAD_BYTES - 1) +: 8] = 8'h00;
            default: ;
        endcase
        return v;
    endfunction

    // main stimulus
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_payload_byte = 8'h00;
        tx_fast        = 1'b0;
        rx_fast        = 1'b0;
        long_hold_req  = 1'b0;
        modulus58 = 1;
        repeat (DIGITS) modulus58 = modulus58 * 58;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed payloads
        send_payload('0);                              // all zero: only '1's
        send_payload({PAYLOAD_BITS{1'b1}});            // all 0xff, wraps
        send_payload(modulus58);                       // wraps to zero: lone '1'
        send_payload(modulus58 - 1);                   // full length of 'z'
        send_payload(modulus58 + 1);                   // wraps to one
        send_payload(PAYLOAD_BITS'(1));                // leading zeros then one digit
        send_payload(PAYLOAD_BITS'(58));               // two digits
        send_payload({8'h00, {(PAYLOAD_BITS - 8){1'b1}}}); // longest text with a '1'
        send_payload({{12{16'hAA55}}, 8'hAA});         // alternating 0xAA and 0x55 bytes

        // random payloads, one of them with no idling
        for (int p = 0; p < 4; p++) begin
            tx_fast = (p % 4 == 3);
            rx_fast = tx_fast;
            send_payload(shaped_value());
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;

        // receiver holds off while payloads keep coming, so the input stalls
        long_hold_req = 1'b1;
        tx_fast = 1'b1;
        repeat (3) send_payload(shaped_value());
        tx_fast = 1'b0;

        // sender pauses until the text is fully out
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);

        for (int p = 0; p < 4; p++) begin
            tx_fast = (p % 4 == 2);
            rx_fast = tx_fast;
            send_payload(shaped_value());
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        i_valid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d payloads and %0d characters in %0d cycles",
                 sb.payloads_done, sb.chars_checked, cycle_count);
        $display("zero, all-ones, wrap-around, leading-zero and long-hold cases included");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
